// ===== rtl/tmst_pkg.sv =====
// ----------------------------------------------------------------------------
// tmst_pkg
// Shared types and constants for the multi-slot timeout timer.
// ----------------------------------------------------------------------------
package tmst_pkg;

  localparam int SLOTS = 16;
  localparam int IDX_W = $clog2(SLOTS);

  localparam logic [1:0] KIND_TICK   = 2'd0;
  localparam logic [1:0] KIND_START  = 2'd1;
  localparam logic [1:0] KIND_STOP   = 2'd2;
  localparam logic [1:0] KIND_CANCEL = 2'd3;

  typedef struct packed {
    logic [1:0]  kind;
    logic [3:0]  slot_id;
    logic [31:0] timeout;
  } in_word_t;

  typedef struct packed {
    logic [3:0]  expired_id;
    logic [31:0] expire_tick;
    logic        last;
  } out_word_t;

  typedef struct packed {
    logic apply;
    logic tick_dec;
    logic scan_clr;
    logic scan_step;
    logic emit;
    logic tick_inc;
  } ctl_cmd_t;

  typedef struct packed {
    logic scan_end;
    logic best_found;
    logic last;
  } dp_stat_t;

endpackage

// ===== rtl/tmst_ctrl.sv =====
// ----------------------------------------------------------------------------
// tmst_ctrl
// Sequencer: applies slot commands, runs the per-result oldest-first scan.
// ----------------------------------------------------------------------------
module tmst_ctrl
  import tmst_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       start,
  input  logic [1:0] kind,
  output logic       busy,
  output ctl_cmd_t   cmd,
  input  dp_stat_t   stat
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_SCAN = 2'd1;
  localparam logic [1:0] ST_EMIT = 2'd2;

  logic [1:0] state_r;
  logic [1:0] state_nxt;

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (start) begin
          if (kind == KIND_TICK) begin
            cmd.tick_dec = 1'b1;
            cmd.scan_clr = 1'b1;
            state_nxt    = ST_SCAN;
          end else begin
            cmd.apply = 1'b1;
          end
        end
      end
      ST_SCAN: begin
        cmd.scan_step = 1'b1;
        if (stat.scan_end) begin
          state_nxt = ST_EMIT;
        end
      end
      ST_EMIT: begin
        cmd.emit = 1'b1;
        if (!stat.best_found || stat.last) begin
          cmd.tick_inc = 1'b1;
          state_nxt    = ST_IDLE;
        end else begin
          cmd.scan_clr = 1'b1;
          state_nxt    = ST_SCAN;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign busy = (state_r != ST_IDLE);

endmodule

// ===== rtl/tmst_dp.sv =====
// ----------------------------------------------------------------------------
// tmst_dp
// Slot bank, tick counter, start sequence and oldest-first selection scan.
// ----------------------------------------------------------------------------
module tmst_dp
  import tmst_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  in_word_t    in_word,
  input  ctl_cmd_t    cmd,
  output dp_stat_t    stat,
  input  logic        tick_load,
  input  logic [31:0] tick_load_value,
  output logic        out_valid,
  output out_word_t   out_word
);

  logic [31:0]      rem_r   [SLOTS];
  logic [31:0]      order_r [SLOTS];
  logic [SLOTS-1:0] armed_r;
  logic [SLOTS-1:0] silent_r;
  logic [SLOTS-1:0] fired_r;
  logic [31:0]      seq_r;
  logic [31:0]      tick_r;
  logic [IDX_W-1:0] scan_idx_r;
  logic             best_found_r;
  logic [IDX_W-1:0] best_id_r;
  logic [31:0]      best_age_r;
  logic             out_valid_r;
  out_word_t        out_word_r;

  logic             id_ok;
  logic [IDX_W-1:0] id;
  logic [31:0]      age;
  logic             better;
  logic [SLOTS-1:0] rest;

  assign id     = IDX_W'(in_word.slot_id);
  assign id_ok  = (32'(in_word.slot_id) < SLOTS);
  assign age    = seq_r - order_r[scan_idx_r];
  assign better = fired_r[scan_idx_r] && (!best_found_r || (age > best_age_r));

  always_comb begin
    rest            = fired_r;
    rest[best_id_r] = 1'b0;
  end

  assign stat.scan_end   = (scan_idx_r == IDX_W'(SLOTS - 1));
  assign stat.best_found = best_found_r;
  assign stat.last       = (rest == '0);

  always_ff @(posedge clk) begin
    if (cmd.apply && id_ok && in_word.kind == KIND_START) begin
      rem_r[id]   <= (in_word.timeout == 32'd0) ? 32'd1 : in_word.timeout;
      order_r[id] <= seq_r;
    end else if (cmd.tick_dec) begin
      for (int i = 0; i < SLOTS; i++) begin
        if (armed_r[i]) begin
          rem_r[i] <= rem_r[i] - 32'd1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      armed_r  <= '0;
      silent_r <= '0;
      fired_r  <= '0;
      seq_r    <= '0;
    end else begin
      if (cmd.apply && id_ok) begin
        unique case (in_word.kind)
          KIND_START: begin
            armed_r[id]  <= 1'b1;
            silent_r[id] <= 1'b0;
            seq_r        <= seq_r + 32'd1;
          end
          KIND_STOP: begin
            armed_r[id] <= 1'b0;
          end
          KIND_CANCEL: begin
            if (armed_r[id]) begin
              silent_r[id] <= 1'b1;
            end
          end
          default: begin
          end
        endcase
      end
      if (cmd.tick_dec) begin
        for (int i = 0; i < SLOTS; i++) begin
          fired_r[i] <= armed_r[i] && (rem_r[i] == 32'd1) && !silent_r[i];
          if (armed_r[i] && rem_r[i] == 32'd1) begin
            armed_r[i] <= 1'b0;
          end
        end
      end else if (cmd.emit && best_found_r) begin
        fired_r[best_id_r] <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tick_r <= '0;
    end else if (tick_load) begin
      tick_r <= tick_load_value;
    end else if (cmd.tick_inc) begin
      tick_r <= tick_r + 32'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scan_idx_r   <= '0;
      best_found_r <= 1'b0;
    end else if (cmd.scan_clr) begin
      scan_idx_r   <= '0;
      best_found_r <= 1'b0;
    end else if (cmd.scan_step) begin
      scan_idx_r <= scan_idx_r + IDX_W'(1);
      if (better) begin
        best_found_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.scan_step && better) begin
      best_id_r  <= scan_idx_r;
      best_age_r <= age;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= cmd.emit && best_found_r;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit && best_found_r) begin
      out_word_r.expired_id  <= 4'(best_id_r);
      out_word_r.expire_tick <= tick_r;
      out_word_r.last        <= (rest == '0);
    end
  end

  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

endmodule

// ===== rtl/multi_slot_timeout_timer.sv =====
// ----------------------------------------------------------------------------
// multi_slot_timeout_timer
// Start, stop and cancel words are applied while idle; busy stays low.
// Tick: busy while the scans run; result k (from 1) strobes after the
// one-slot-a-cycle oldest-first scan that selects it, which runs once per
// result, or once if no slot fired.
// Reset (synchronous, active low) disarms all slots and clears the tick count.
// ----------------------------------------------------------------------------
module multi_slot_timeout_timer
  import tmst_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  in_word_t    in_word,
  output logic        out_valid,
  output out_word_t   out_word,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic [31:0] tcs_r;
  logic        cfg_wr;
  logic        cfg_load;
  ctl_cmd_t    cmd;
  dp_stat_t    stat;

  assign pready   = 1'b1;
  assign cfg_wr   = psel && penable && pwrite && pready;
  assign cfg_load = cfg_wr && !paddr[2];
  assign prdata   = paddr[2] ? 32'd0 : tcs_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tcs_r <= '0;
    end else if (cfg_load) begin
      tcs_r <= pwdata;
    end
  end

  tmst_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .kind  (in_word.kind),
    .busy  (busy),
    .cmd   (cmd),
    .stat  (stat)
  );

  tmst_dp u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_word         (in_word),
    .cmd             (cmd),
    .stat            (stat),
    .tick_load       (cfg_load),
    .tick_load_value (pwdata),
    .out_valid       (out_valid),
    .out_word        (out_word)
  );

  a_tick_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy && in_word.kind == KIND_TICK |=> busy)
    else $error("tick word did not start a scan");

  a_cmd_idle: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy && in_word.kind != KIND_TICK |=> !busy && !out_valid)
    else $error("slot command left the block busy or strobed a result");

  a_more_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_word.last |-> busy)
    else $error("non-final result without a pending scan");

  a_strobe_gap: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("results strobed in adjacent cycles");

endmodule
